[sv/svd_pkg.sv]
`default_nettype none
package svd_pkg;

  localparam int unsigned DERIV_GAIN_DEF  = 0;
  localparam int unsigned WINDOW_DEF      = 13107200;
  localparam int unsigned VEL_CAL_DEF     = 3277;
  localparam int unsigned NEAR_PASSES_DEF = 5;
  localparam int unsigned INT_CLAMP_DEF   = 13107200;

  // shared shift-add multiplier: A is the wide operand, B is scanned one bit a cycle
  localparam int MUL_AW = 64;
  localparam int MUL_BW = 32;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int MUL_CW = $clog2(MUL_BW);

  // digit-by-digit square root, two radicand bits a cycle
  localparam int SQ_XW = 64;
  localparam int SQ_RW = SQ_XW / 2;
  localparam int SQ_CW = $clog2(SQ_RW);

  typedef enum logic [2:0] {
    REG_GAIN_SQRT,
    REG_GAIN_PROP,
    REG_GAIN_INT,
    REG_POS_MIN,
    REG_POS_MAX,
    REG_VEL_LIMIT,
    REG_ACC_LIMIT,
    REG_JERK_LIMIT
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PREP,
    ST_M_APG,
    ST_M_APGG,
    ST_M_GSS,
    ST_SQ_ERR,
    ST_M_TERM,
    ST_M_VCAL,
    ST_INTG,
    ST_INT_GO,
    ST_M_INT,
    ST_DER_GO,
    ST_M_DER,
    ST_LIM1,
    ST_LIM2,
    ST_STOP_GO,
    ST_M_STOP,
    ST_SQ_STOP,
    ST_FIN
  } state_t;

endpackage
`default_nettype wire

[sv/axis_servo_velocity_demand.sv]
`default_nettype none
// Channel | Handshake          | Payload
// cfg     | cfg_write          | cfg_index, cfg_data
// in      | in_valid/in_ready  | new_move, pos_demand, vel_advise, pos_actual, vel_actual,
//         |                    | near_window
// out     | out_valid/out_ready| vel_demand, in_position
//
// One item at a time: the next item is accepted only after the previous one has finished.
// Most of the work is the bit-serial multiplier (up to seven products) and the square-root
// unit (used for the slew law and the stopping-distance limit).
// rst is synchronous; it clears the servo state and loads the register defaults.
// A finished item waits in the output register while the next item is accepted.
module axis_servo_velocity_demand #(
  parameter int unsigned DERIV_GAIN  = svd_pkg::DERIV_GAIN_DEF,
  parameter int unsigned WINDOW      = svd_pkg::WINDOW_DEF,
  parameter int unsigned VEL_CAL     = svd_pkg::VEL_CAL_DEF,
  parameter int unsigned NEAR_PASSES = svd_pkg::NEAR_PASSES_DEF,
  parameter int unsigned INT_CLAMP   = svd_pkg::INT_CLAMP_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               new_move,
  input  wire logic signed [31:0] pos_demand,
  input  wire logic signed [31:0] vel_advise,
  input  wire logic signed [31:0] pos_actual,
  input  wire logic signed [31:0] vel_actual,
  input  wire logic [30:0]        near_window,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      vel_demand,
  output logic                    in_position
);

  localparam logic [32:0]        INT_CLAMP_C = 33'(INT_CLAMP);
  localparam logic signed [36:0] WINDOW_C    = 37'(WINDOW);
  localparam logic [31:0]        VEL_CAL_C   = 32'(VEL_CAL);
  localparam logic [31:0]        DG_C        = 32'(DERIV_GAIN);
  localparam logic [3:0]         NP_C        = 4'(NEAR_PASSES);
  localparam logic signed [47:0] INT48_MAX   = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] INT48_MIN   = {1'b1, {47{1'b0}}};
  localparam logic signed [35:0] MAX32_36    = 36'sd2147483647;
  localparam logic signed [35:0] MIN32_36    = -36'sd2147483648;

  svd_pkg::state_t state, state_next;

  // registers
  logic [23:0]        gs, gp, gi;
  logic signed [31:0] pmin, pmax;
  logic [30:0]        vlim, alim, jlim;

  logic signed [31:0] last_error;
  logic signed [47:0] integ_near, integ_far;
  logic signed [31:0] vh [3];
  logic [2:0]         near_count;

  logic signed [31:0] pd_r, va_r, pt_r;
  logic [30:0]        pnear_r;
  logic signed [32:0] pe_r;
  logic [32:0]        ape_r;
  logic               inpos_r;
  logic [56:0]        m1;
  logic [80:0]        m2;
  logic signed [35:0] fs_r;
  logic signed [47:0] accum;
  logic signed [47:0] vdp;
  logic signed [32:0] da0_r;
  logic signed [31:0] vcur;
  logic signed [31:0] res_r;

  // unit handshakes
  logic                         mul_start, mul_done;
  logic [svd_pkg::MUL_AW-1:0]   mul_a;
  logic [svd_pkg::MUL_BW-1:0]   mul_b;
  logic [svd_pkg::MUL_PW-1:0]   mul_p;
  logic                         sq_start, sq_done;
  logic [svd_pkg::SQ_XW-1:0]    sq_x;
  logic [svd_pkg::SQ_RW-1:0]    sq_root;

  // combinational values
  logic signed [31:0] pdc;
  logic signed [32:0] pe_c;
  logic [32:0]        ape_c;
  logic [3:0]         cnt_c;
  logic               slew_c;
  logic [31:0]        va_mag;
  logic [49:0]        q_up;
  logic signed [35:0] fs_c;
  logic signed [36:0] thr_c;
  logic               near_c;
  logic signed [32:0] daccum_c;
  logic signed [47:0] isel_c;
  logic signed [48:0] isum_c;
  logic signed [47:0] isat_c;
  logic [57:0]        m1_up;
  logic signed [41:0] pterm_c;
  logic signed [33:0] tterm_c;
  logic [47:0]        acc_mag;
  logic [47:0]        n_c;
  logic               big_c;
  logic [47:0]        pint_up;
  logic signed [32:0] small_c;
  logic signed [32:0] vl_s;
  logic signed [32:0] vi_c;
  logic signed [33:0] diff_c;
  logic [33:0]        diff_mag;
  logic [58:0]        d_up;
  logic signed [42:0] dterm_c;
  logic signed [47:0] vl48;
  logic signed [47:0] vcl48;
  logic signed [32:0] d_c;
  logic signed [32:0] al33;
  logic signed [32:0] da0_c;
  logic signed [31:0] le_sat;
  logic signed [32:0] dam1_c;
  logic signed [33:0] dd_c;
  logic signed [33:0] jl34;
  logic signed [33:0] dj0_c;
  logic signed [35:0] vs_c;
  logic signed [31:0] vsat_c;
  logic signed [32:0] dlr_c;
  logic [31:0]        dl_c;
  logic signed [33:0] r34;
  logic signed [33:0] vc34;
  logic signed [33:0] res34;

  svd_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  svd_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .x     (sq_x),
    .done  (sq_done),
    .root  (sq_root)
  );

  // ---- error and in-position window
  assign pdc = (pd_r < pmin) ? pmin : ((pd_r > pmax) ? pmax : pd_r);
  assign pe_c  = 33'(pdc) - 33'(pt_r);
  assign ape_c = pe_c[32] ? 33'(-pe_c) : 33'(pe_c);
  assign cnt_c = (ape_c > {2'b00, pnear_r}) ? 4'd0 : {1'b0, near_count} + 4'd1;

  // slew when |pe|*gp*gp > gs*gs*2^16
  assign slew_c = (gp != '0) && (m2 > {17'd0, mul_p[47:0], 16'd0});

  // ---- anti-windup window, floor of va*VEL_CAL/2^16
  assign va_mag = va_r[31] ? 32'(-va_r) : 32'(va_r);
  assign q_up   = {1'b0, mul_p[48:0]} + 50'd65535;
  assign fs_c   = va_r[31] ? -$signed(36'(q_up[49:16])) : $signed(36'(mul_p[48:16]));
  assign thr_c  = WINDOW_C + 37'(fs_r);
  assign near_c = $signed({4'd0, ape_r}) < thr_c;

  assign daccum_c = (ape_r < INT_CLAMP_C) ? pe_r
                  : (pe_r[32] ? -$signed(INT_CLAMP_C) : $signed(INT_CLAMP_C));
  assign isel_c = near_c ? integ_near : integ_far;
  assign isum_c = 49'(isel_c) + 49'(daccum_c);
  assign isat_c = (isum_c[48] != isum_c[47]) ? (isum_c[48] ? INT48_MIN : INT48_MAX)
                                             : isum_c[47:0];

  // proportional term reuses |pe|*gp
  assign m1_up   = {1'b0, m1} + 58'd65535;
  assign pterm_c = pe_r[32] ? -$signed(42'(m1_up[57:16])) : $signed(42'(m1[56:16]));

  // square-root law term
  assign tterm_c = $signed({1'b0, mul_p[48:16]});

  // ---- integral term: |accum| > floor(N/gi) is tested as |accum|*gi > N
  assign acc_mag = accum[47] ? 48'(-accum) : 48'(accum);
  assign n_c     = {(32'(vlim) + 32'd1), 16'd0} - 48'd1;
  assign big_c   = mul_p[71:0] > {24'd0, n_c};
  assign pint_up = mul_p[47:0] + 48'd65535;
  assign small_c = accum[47] ? -$signed(33'(pint_up[47:16])) : $signed(33'(mul_p[47:16]));
  assign vl_s    = $signed({2'b00, vlim});
  assign vi_c    = big_c ? (accum[47] ? -vl_s : vl_s)
                 : ((small_c > vl_s) ? vl_s : ((small_c < -vl_s) ? -vl_s : small_c));

  // ---- derivative term
  assign diff_c   = 34'(pe_r) - 34'(last_error);
  assign diff_mag = diff_c[33] ? 34'(-diff_c) : 34'(diff_c);
  assign d_up     = {1'b0, mul_p[57:0]} + 59'd65535;
  assign dterm_c  = diff_c[33] ? -$signed(43'(d_up[58:16])) : $signed(43'(mul_p[57:16]));

  // ---- velocity, acceleration, jerk limits
  assign vl48   = $signed({17'd0, vlim});
  assign vcl48  = (vdp > vl48) ? vl48 : ((vdp < -vl48) ? -vl48 : vdp);
  assign d_c    = 33'($signed(vcl48[31:0])) - 33'(vh[0]);
  assign al33   = $signed({2'b00, alim});
  assign da0_c  = (d_c > al33) ? al33 : ((d_c < -al33) ? -al33 : d_c);
  assign le_sat = (pe_r[32] != pe_r[31]) ? (pe_r[32] ? 32'sh80000000 : 32'sh7fffffff)
                                         : pe_r[31:0];

  assign dam1_c = 33'(vh[0]) - 33'(vh[1]);
  assign dd_c   = 34'(da0_r) - 34'(dam1_c);
  assign jl34   = $signed({3'b000, jlim});
  assign dj0_c  = (dd_c > jl34) ? jl34 : ((dd_c < -jl34) ? -jl34 : dd_c);
  assign vs_c   = 36'(dj0_c) + 36'(dam1_c) + 36'(vh[0]);
  assign vsat_c = (vs_c > MAX32_36) ? 32'sh7fffffff
                : ((vs_c < MIN32_36) ? 32'sh80000000 : vs_c[31:0]);

  // ---- stopping distance limit
  assign dlr_c = vcur[31] ? (33'(pt_r) - 33'(pmin)) : (33'(pmax) - 33'(pt_r));
  assign dl_c  = dlr_c[32] ? 32'd0 : dlr_c[31:0];
  assign r34   = $signed({2'b00, sq_root});
  assign vc34  = 34'(vcur);
  assign res34 = !vcur[31] ? ((vc34 > r34) ? r34 : vc34)
                           : ((vc34 < -r34) ? -r34 : vc34);

  // ---- next state
  always_comb begin
    state_next = state;
    unique case (state)
      svd_pkg::ST_IDLE:    if (in_valid) state_next = svd_pkg::ST_PREP;
      svd_pkg::ST_PREP:    state_next = svd_pkg::ST_M_APG;
      svd_pkg::ST_M_APG:   if (mul_done) state_next = svd_pkg::ST_M_APGG;
      svd_pkg::ST_M_APGG:  if (mul_done) state_next = svd_pkg::ST_M_GSS;
      svd_pkg::ST_M_GSS: begin
        if (mul_done) state_next = slew_c ? svd_pkg::ST_SQ_ERR : svd_pkg::ST_M_VCAL;
      end
      svd_pkg::ST_SQ_ERR:  if (sq_done) state_next = svd_pkg::ST_M_TERM;
      svd_pkg::ST_M_TERM:  if (mul_done) state_next = svd_pkg::ST_LIM1;
      svd_pkg::ST_M_VCAL:  if (mul_done) state_next = svd_pkg::ST_INTG;
      svd_pkg::ST_INTG:    state_next = svd_pkg::ST_INT_GO;
      svd_pkg::ST_INT_GO:  state_next = (gi != '0) ? svd_pkg::ST_M_INT : svd_pkg::ST_DER_GO;
      svd_pkg::ST_M_INT:   if (mul_done) state_next = svd_pkg::ST_DER_GO;
      svd_pkg::ST_DER_GO:  state_next = (DG_C != '0) ? svd_pkg::ST_M_DER : svd_pkg::ST_LIM1;
      svd_pkg::ST_M_DER:   if (mul_done) state_next = svd_pkg::ST_LIM1;
      svd_pkg::ST_LIM1:    state_next = svd_pkg::ST_LIM2;
      svd_pkg::ST_LIM2:    state_next = svd_pkg::ST_STOP_GO;
      svd_pkg::ST_STOP_GO: state_next = svd_pkg::ST_M_STOP;
      svd_pkg::ST_M_STOP:  if (mul_done) state_next = svd_pkg::ST_SQ_STOP;
      svd_pkg::ST_SQ_STOP: if (sq_done) state_next = svd_pkg::ST_FIN;
      svd_pkg::ST_FIN:     if (!out_valid || out_ready) state_next = svd_pkg::ST_IDLE;
      default:             state_next = svd_pkg::ST_IDLE;
    endcase
  end

  // ---- unit requests
  always_comb begin
    in_ready  = (state == svd_pkg::ST_IDLE);
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    sq_start  = 1'b0;
    sq_x      = '0;
    unique case (state)
      svd_pkg::ST_PREP: begin
        mul_start = 1'b1;
        mul_a     = svd_pkg::MUL_AW'(ape_c);
        mul_b     = svd_pkg::MUL_BW'(gp);
      end
      svd_pkg::ST_M_APG: begin
        mul_start = mul_done;
        mul_a     = svd_pkg::MUL_AW'(mul_p[56:0]);
        mul_b     = svd_pkg::MUL_BW'(gp);
      end
      svd_pkg::ST_M_APGG: begin
        mul_start = mul_done;
        mul_a     = svd_pkg::MUL_AW'(gs);
        mul_b     = svd_pkg::MUL_BW'(gs);
      end
      svd_pkg::ST_M_GSS: begin
        if (slew_c) begin
          sq_start = mul_done;
          sq_x     = svd_pkg::SQ_XW'({ape_r, 16'd0});
        end else begin
          mul_start = mul_done;
          mul_a     = svd_pkg::MUL_AW'(va_mag);
          mul_b     = svd_pkg::MUL_BW'(VEL_CAL_C);
        end
      end
      svd_pkg::ST_SQ_ERR: begin
        mul_start = sq_done;
        mul_a     = svd_pkg::MUL_AW'(sq_root);
        mul_b     = svd_pkg::MUL_BW'(gs);
      end
      svd_pkg::ST_INT_GO: begin
        mul_start = (gi != '0);
        mul_a     = svd_pkg::MUL_AW'(acc_mag);
        mul_b     = svd_pkg::MUL_BW'(gi);
      end
      svd_pkg::ST_DER_GO: begin
        mul_start = (DG_C != '0);
        mul_a     = svd_pkg::MUL_AW'(diff_mag);
        mul_b     = svd_pkg::MUL_BW'(DG_C);
      end
      svd_pkg::ST_STOP_GO: begin
        mul_start = 1'b1;
        mul_a     = svd_pkg::MUL_AW'(dl_c);
        mul_b     = svd_pkg::MUL_BW'({alim, 1'b0});
      end
      svd_pkg::ST_M_STOP: begin
        sq_start = mul_done;
        sq_x     = svd_pkg::SQ_XW'(mul_p[63:0]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= svd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gs   <= '0;
      gp   <= '0;
      gi   <= '0;
      pmin <= 32'sh80000000;
      pmax <= 32'sh7fffffff;
      vlim <= '0;
      alim <= '0;
      jlim <= '0;
    end else if (cfg_write) begin
      unique case (svd_pkg::reg_idx_t'(cfg_index))
        svd_pkg::REG_GAIN_SQRT:  gs   <= cfg_data[23:0];
        svd_pkg::REG_GAIN_PROP:  gp   <= cfg_data[23:0];
        svd_pkg::REG_GAIN_INT:   gi   <= cfg_data[23:0];
        svd_pkg::REG_POS_MIN:    pmin <= cfg_data;
        svd_pkg::REG_POS_MAX:    pmax <= cfg_data;
        svd_pkg::REG_VEL_LIMIT:  vlim <= cfg_data[30:0];
        svd_pkg::REG_ACC_LIMIT:  alim <= cfg_data[30:0];
        svd_pkg::REG_JERK_LIMIT: jlim <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

  // servo state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      integ_near <= '0;
      integ_far  <= '0;
      vh[0]      <= '0;
      vh[1]      <= '0;
      vh[2]      <= '0;
      near_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (state == svd_pkg::ST_FIN && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        svd_pkg::ST_IDLE: begin
          if (in_valid && new_move) begin
            last_error <= '0;
            integ_near <= '0;
            integ_far  <= '0;
            vh[0]      <= vel_actual;
            vh[1]      <= vel_actual;
            vh[2]      <= vel_actual;
            near_count <= '0;
          end
        end
        svd_pkg::ST_PREP: begin
          near_count <= (cnt_c < NP_C) ? cnt_c[2:0] : NP_C[2:0];
        end
        svd_pkg::ST_M_GSS: begin
          if (mul_done && slew_c) begin
            integ_near <= '0;
            integ_far  <= '0;
          end
        end
        svd_pkg::ST_INTG: begin
          if (near_c) begin
            integ_near <= isat_c;
            integ_far  <= '0;
          end else begin
            integ_far  <= isat_c;
            integ_near <= '0;
          end
        end
        svd_pkg::ST_LIM1: begin
          last_error <= le_sat;
        end
        svd_pkg::ST_LIM2: begin
          vh[2] <= vh[1];
          vh[1] <= vh[0];
          vh[0] <= vsat_c;
        end
        default: begin
        end
      endcase
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    unique case (state)
      svd_pkg::ST_IDLE: begin
        if (in_valid) begin
          pd_r    <= pos_demand;
          va_r    <= vel_advise;
          pt_r    <= pos_actual;
          pnear_r <= near_window;
        end
      end
      svd_pkg::ST_PREP: begin
        pe_r    <= pe_c;
        ape_r   <= ape_c;
        inpos_r <= !(cnt_c < NP_C);
      end
      svd_pkg::ST_M_APG:  if (mul_done) m1 <= mul_p[56:0];
      svd_pkg::ST_M_APGG: if (mul_done) m2 <= mul_p[80:0];
      svd_pkg::ST_M_TERM: begin
        if (mul_done) begin
          vdp <= 48'(va_r) + (pe_r[32] ? -48'(tterm_c) : 48'(tterm_c));
        end
      end
      svd_pkg::ST_M_VCAL: if (mul_done) fs_r <= fs_c;
      svd_pkg::ST_INTG: begin
        accum <= isat_c;
        vdp   <= 48'(va_r) + 48'(pterm_c);
      end
      svd_pkg::ST_M_INT:  if (mul_done) vdp <= vdp + 48'(vi_c);
      svd_pkg::ST_M_DER:  if (mul_done) vdp <= vdp + 48'(dterm_c);
      svd_pkg::ST_LIM1:   da0_r <= da0_c;
      svd_pkg::ST_LIM2:   vcur <= vsat_c;
      svd_pkg::ST_SQ_STOP: if (sq_done) res_r <= res34[31:0];
      svd_pkg::ST_FIN: begin
        if (!out_valid || out_ready) begin
          vel_demand  <= res_r;
          in_position <= inpos_r;
        end
      end
      default: begin
      end
    endcase
  end

  a_integ_excl: assert property (@(posedge clk) disable iff (rst)
    !(integ_near != '0 && integ_far != '0))
    else $error("both integrators nonzero");

  a_near_cnt: assert property (@(posedge clk) disable iff (rst)
    near_count <= NP_C[2:0])
    else $error("near count beyond pass count");

  a_unit_excl: assert property (@(posedge clk) disable iff (rst)
    !(mul_start && sq_start))
    else $error("multiplier and root started together");

  a_slew_clear: assert property (@(posedge clk) disable iff (rst)
    (state == svd_pkg::ST_SQ_ERR) |-> (integ_near == '0 && integ_far == '0))
    else $error("integrators not cleared on slew path");

  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == svd_pkg::ST_FIN && out_valid && !out_ready) |=> (state == svd_pkg::ST_FIN))
    else $error("result dropped while output busy");

endmodule
`default_nettype wire

[sv/svd_mul.sv]
`default_nettype none
module svd_mul (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [svd_pkg::MUL_AW-1:0]  a,
  input  wire logic [svd_pkg::MUL_BW-1:0]  b,
  output logic                             done,
  output logic [svd_pkg::MUL_PW-1:0]       p
);

  logic [svd_pkg::MUL_AW-1:0] a_r;
  logic [svd_pkg::MUL_PW-1:0] prod;
  logic [svd_pkg::MUL_CW-1:0] cnt;
  logic                       busy;
  logic [svd_pkg::MUL_AW:0]   sum;

  // upper half plus A when the current multiplier bit is set; product shifts right
  assign sum = {1'b0, prod[svd_pkg::MUL_PW-1:svd_pkg::MUL_BW]}
             + (prod[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == svd_pkg::MUL_CW'(svd_pkg::MUL_BW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      prod <= {{svd_pkg::MUL_AW{1'b0}}, b};
    end else if (busy) begin
      prod <= {sum, prod[svd_pkg::MUL_BW-1:1]};
    end
  end

  assign p = prod;

endmodule
`default_nettype wire

[sv/svd_sqrt.sv]
`default_nettype none
module svd_sqrt (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [svd_pkg::SQ_XW-1:0]  x,
  output logic                            done,
  output logic [svd_pkg::SQ_RW-1:0]       root
);

  logic [svd_pkg::SQ_XW-1:0] rad;
  logic [svd_pkg::SQ_RW+1:0] rem;
  logic [svd_pkg::SQ_RW-1:0] rt;
  logic [svd_pkg::SQ_CW-1:0] cnt;
  logic                      busy;
  logic [svd_pkg::SQ_RW+3:0] t;
  logic [svd_pkg::SQ_RW+3:0] trial;
  logic                      fits;

  assign t     = {rem, rad[svd_pkg::SQ_XW-1:svd_pkg::SQ_XW-2]};
  assign trial = {2'b00, rt, 2'b01};
  assign fits  = (t >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == svd_pkg::SQ_CW'(svd_pkg::SQ_RW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad <= x;
      rem <= '0;
      rt  <= '0;
    end else if (busy) begin
      rad <= {rad[svd_pkg::SQ_XW-3:0], 2'b00};
      rem <= fits ? (svd_pkg::SQ_RW+2)'(t - trial) : (svd_pkg::SQ_RW+2)'(t);
      rt  <= {rt[svd_pkg::SQ_RW-2:0], fits};
    end
  end

  assign root = rt;

endmodule
`default_nettype wire
